// File: rtl/core/mexp_pkg.sv
`timescale 1ns / 1ps
// mexp_pkg: widths, codes, controller states, command/status structs and
// the modular arithmetic step functions of the modular exponentiation block.
// No dependencies.
package mexp_pkg;

  localparam int OP_W       = 63;
  localparam int RES_W      = 32;
  localparam int EXP_IN_W   = 32;
  localparam int ACT_W      = 2;
  localparam int EXP_BITS_DEF = 32;
  localparam int CNT_W      = 6;
  localparam logic [RES_W-1:0] MOD_RESET = 32'd1000000007;
  localparam logic [CNT_W-1:0] RED_LAST  = CNT_W'(OP_W - 1);
  localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(RES_W - 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_POW = 2'd0,
    ACT_INV = 2'd1,
    ACT_DIV = 2'd2
  } act_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED,
    S_CHECK,
    S_RSTART,
    S_RMUL,
    S_RSTORE,
    S_FSTART,
    S_FMUL,
    S_FSTORE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic red_step;
    logic x_load;
    logic clr_acc;
    logic mul_start;
    logic fin_start;
    logic mul_step;
    logic round_commit;
    logic fin_commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic act_ok;
    logic is_div;
    logic m_zero;
    logic x_zero;
  } sts_t;

  // one bit of r*2+bit mod m, r < m
  function automatic logic [RES_W-1:0] red_bit(input logic [RES_W-1:0] r,
                                               input logic bit_in,
                                               input logic [RES_W-1:0] m);
    logic [RES_W:0] t;
    t = {r, bit_in};
    if (t >= {1'b0, m}) t = t - {1'b0, m};
    return t[RES_W-1:0];
  endfunction

  // interleaved modular multiply step: (2*acc + bit*p) mod m, acc,p < m
  function automatic logic [RES_W-1:0] mm_step(input logic [RES_W-1:0] acc,
                                               input logic [RES_W-1:0] p,
                                               input logic bit_in,
                                               input logic [RES_W-1:0] m);
    logic [RES_W+1:0] t;
    logic [RES_W+1:0] m1;
    logic [RES_W+1:0] m2;
    t  = {1'b0, acc, 1'b0} + (bit_in ? {2'b00, p} : '0);
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    if (t >= m2)      t = t - m2;
    else if (t >= m1) t = t - m1;
    return t[RES_W-1:0];
  endfunction

endpackage

// File: rtl/core/mexp_if.sv
`timescale 1ns / 1ps
// mexp_if: request and response channel interfaces (valid/ready + payload).
// Depends on mexp_pkg.
interface mexp_req_if import mexp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [OP_W-1:0]     operand_a;
  logic [OP_W-1:0]     operand_b;
  logic [EXP_IN_W-1:0] exponent;
  modport source (output valid, action, operand_a, operand_b, exponent, input ready);
  modport sink   (input valid, action, operand_a, operand_b, exponent, output ready);
endinterface

interface mexp_rsp_if import mexp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] result;
  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

// File: rtl/core/modular_exponentiation.sv
`timescale 1ns / 1ps
// modular_exponentiation: power, Fermat inverse and divide modulo a runtime modulus.
// Sequence: bit-serial operand reduction, a check state, one square-and-multiply round per
// exponent bit (plus a final multiply for divide), then done; zero base skips the rounds.
// One item at a time: a new request is taken only while the controller is idle.
// Reset (rst, synchronous): controller idle, no result pending, modulus = 1000000007.
module modular_exponentiation import mexp_pkg::*; #(
  parameter int EXP_BITS = EXP_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  mexp_req_if.sink         req,
  mexp_rsp_if.source       rsp,
  input  logic             cfg_we,
  input  logic [RES_W-1:0] cfg_wdata
);

  // controller <-> datapath
  cmd_t cmd;
  sts_t sts;

  mexp_ctrl #(.EXP_BITS(EXP_BITS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // result register holds the item while the next one is worked on
  mexp_datapath #(.EXP_BITS(EXP_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .action    (req.action),
    .operand_a (req.operand_a),
    .operand_b (req.operand_b),
    .exponent  (req.exponent),
    .cmd       (cmd),
    .sts       (sts),
    .result    (rsp.result)
  );

endmodule

// File: rtl/core/mexp_datapath.sv
`timescale 1ns / 1ps
// mexp_datapath: modulus register, operand reducers, two modular multiply
// units, accumulator and result register. Depends on mexp_pkg.
module mexp_datapath import mexp_pkg::*; #(
  parameter int EXP_BITS = EXP_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [RES_W-1:0]    cfg_wdata,
  input  logic [ACT_W-1:0]    action,
  input  logic [OP_W-1:0]     operand_a,
  input  logic [OP_W-1:0]     operand_b,
  input  logic [EXP_IN_W-1:0] exponent,
  input  cmd_t                cmd,
  output sts_t                sts,
  output logic [RES_W-1:0]    result
);

  logic [RES_W-1:0]    m;
  logic [ACT_W-1:0]    act;
  logic [OP_W-1:0]     a_sh, b_sh;
  logic [RES_W-1:0]    ra, rb, x, acc;
  logic [EXP_BITS-1:0] e;
  logic [RES_W-1:0]    macc_a, macc_b, pa, pb, qa, qb;
  logic [RES_W-1:0]    e_src, x_sel;
  logic [63:0]         e_ext;

  // inverse and divide both run the Fermat exponent m - 2
  assign e_src = (action == ACT_POW) ? exponent : (m - RES_W'(2));
  assign e_ext = {32'd0, e_src};
  assign x_sel = (act == ACT_DIV) ? rb : ra;

  assign sts.act_ok = (act == ACT_POW) || (act == ACT_INV) || (act == ACT_DIV);
  assign sts.is_div = (act == ACT_DIV);
  assign sts.m_zero = (m == '0);
  assign sts.x_zero = (x_sel == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      m <= MOD_RESET;
    end else if (cfg_we) begin
      m <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act  <= action;
      a_sh <= operand_a;
      b_sh <= operand_b;
      ra   <= '0;
      rb   <= '0;
      e    <= e_ext[EXP_BITS-1:0];
      acc  <= (m == RES_W'(1)) ? '0 : RES_W'(1);
    end
    if (cmd.red_step) begin
      ra   <= red_bit(ra, a_sh[OP_W-1], m);
      rb   <= red_bit(rb, b_sh[OP_W-1], m);
      a_sh <= {a_sh[OP_W-2:0], 1'b0};
      b_sh <= {b_sh[OP_W-2:0], 1'b0};
    end
    if (cmd.x_load) x <= x_sel;
    if (cmd.clr_acc) acc <= '0;
    if (cmd.mul_start) begin
      macc_a <= '0;
      macc_b <= '0;
      qa     <= acc;
      pa     <= x;
      qb     <= x;
      pb     <= x;
    end
    if (cmd.fin_start) begin
      macc_a <= '0;
      qa     <= acc;
      pa     <= ra;
    end
    if (cmd.mul_step) begin
      macc_a <= mm_step(macc_a, pa, qa[RES_W-1], m);
      macc_b <= mm_step(macc_b, pb, qb[RES_W-1], m);
      qa     <= {qa[RES_W-2:0], 1'b0};
      qb     <= {qb[RES_W-2:0], 1'b0};
    end
    if (cmd.round_commit) begin
      if (e[0]) acc <= macc_a;
      x <= macc_b;
      e <= e >> 1;
    end
    if (cmd.fin_commit) acc <= macc_a;
    if (cmd.out_load) result <= acc;
  end

endmodule

// File: rtl/core/mexp_ctrl.sv
`timescale 1ns / 1ps
// mexp_ctrl: sequencer for reduction, square-and-multiply rounds and the
// final divide product; owns the output valid flag. Depends on mexp_pkg.
module mexp_ctrl import mexp_pkg::*; #(
  parameter int EXP_BITS = EXP_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam int RW = $clog2(EXP_BITS + 1);

  state_t          state, state_next;
  logic [CNT_W-1:0] cnt;
  logic [RW-1:0]    rnd;
  logic             out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_RED;
      S_RED:    if (cnt == RED_LAST) state_next = S_CHECK;
      S_CHECK:  state_next = (sts.m_zero || !sts.act_ok || sts.x_zero) ? S_DONE : S_RSTART;
      S_RSTART: state_next = S_RMUL;
      S_RMUL:   if (cnt == MUL_LAST) state_next = S_RSTORE;
      S_RSTORE: begin
        if (rnd == RW'(1)) state_next = sts.is_div ? S_FSTART : S_DONE;
        else state_next = S_RSTART;
      end
      S_FSTART: state_next = S_FMUL;
      S_FMUL:   if (cnt == MUL_LAST) state_next = S_FSTORE;
      S_FSTORE: state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:   cmd.load = in_valid;
      S_RED:    cmd.red_step = 1'b1;
      S_CHECK: begin
        cmd.x_load  = 1'b1;
        cmd.clr_acc = sts.m_zero || !sts.act_ok || sts.x_zero;
      end
      S_RSTART: cmd.mul_start = 1'b1;
      S_RMUL:   cmd.mul_step = 1'b1;
      S_RSTORE: cmd.round_commit = 1'b1;
      S_FSTART: cmd.fin_start = 1'b1;
      S_FMUL:   cmd.mul_step = 1'b1;
      S_FSTORE: cmd.fin_commit = 1'b1;
      S_DONE:   cmd.out_load = out_free;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rnd       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_RED || state == S_RMUL || state == S_FMUL) cnt <= cnt + CNT_W'(1);
      else cnt <= '0;
      if (state == S_IDLE) rnd <= RW'(EXP_BITS);
      else if (state == S_RSTORE) rnd <= rnd - RW'(1);
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    !(cmd.red_step && cmd.mul_step))
    else $error("reduce and multiply steps overlap");
  a_red_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_RED) |-> (cnt <= RED_LAST))
    else $error("reduction counter overrun");
  a_rnd_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_RMUL) |-> (rnd != '0))
    else $error("round counter empty during multiply");
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside done state");

endmodule
